[rtl/core/tsd_pkg.sv]
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types, constants and the byte-wide CRC-8 function for the
// thermometer scratchpad decoder.
// ----------------------------------------------------------------------------
package tsd_pkg;

    // Status codes of a result
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;

    // Reflected 1-Wire CRC-8 polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Family codes that carry a 12-bit reading with 4 fraction bits
    localparam logic [7:0] FAMILY_A     = 8'h22;
    localparam logic [7:0] FAMILY_B     = 8'h28;
    localparam logic [7:0] FAMILY_EMPTY = 8'h00;

    // Fixed reading reported for any other family
    localparam logic [15:0] DEFAULT_TEMP = 16'd85;

    // One fraction step in ten-thousandths of a degree
    localparam logic [9:0] FRAC_STEP = 10'd625;

    // Reset value of the clamp register
    localparam logic [15:0] MAX_TEMP_RESET = 16'h7FFF;

    // One input item
    typedef struct packed {
        logic signed [7:0] temp_adjust;
        logic        [7:0] family_code;
        logic        [7:0] data_byte;
    } item_t;

    // One result item
    typedef struct packed {
        logic        [1:0]  status;
        logic        [13:0] temp_fraction;
        logic signed [15:0] temp_integer;
    } result_t;

    // CRC-8 over one byte, LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
        logic [7:0] crc;
        logic [7:0] din;
        logic       mix;
        crc = crc_in;
        din = data_in;
        for (int k = 0; k < 8; k++)
        begin
            mix = crc[0] ^ din[0];
            crc = crc >> 1;
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
            din = din >> 1;
        end
        return crc;
    endfunction

endpackage

[rtl/core/thermometer_scratchpad_decoder_core.sv]
// ----------------------------------------------------------------------------
// thermometer_scratchpad_decoder_core
// Checks the CRC of a bus thermometer scratchpad and decodes its reading.
// ----------------------------------------------------------------------------
// Usage:
//   Scratchpad bytes arrive on the s_axis channel, byte 0 first, one per
//   transfer. The family code and adjustment are sampled with the last byte
//   of each scratchpad. After SCRATCHPAD_LENGTH transfers one result leaves
//   on m_axis; earlier bytes give no result.
//   cfg_data sets the signed upper clamp; write it only while idle. cfg_ready
//   is always high.
// Throughput: one byte per cycle while m_axis does not stall, limited by the
//   single input register and the single result register.
// Path: the transfer of the last byte loads the input register; the decoded
//   result then goes into the result register once that register is free,
//   and leaves on m_axis from there.
// Reset: CRC, byte position and raw bytes clear; clamp returns to 32767; no
//   result is pending.
// Stall: a stalled m_axis holds its result and halts every byte; the input
//   register holds at most one byte, and once it is full s_axis_tready drops.
// ----------------------------------------------------------------------------
module thermometer_scratchpad_decoder_core
#(
    parameter int SCRATCHPAD_LENGTH = 9
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,       // max_temperature (signed)
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [15:8] temp_adjust
    input  logic [7:0]  s_axis_tuser,   // [7:0] family_code
    // result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] temp_integer, [29:16] temp_fraction,
                                        // [31:30] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic [15:0]      max_temp_reg;
    tsd_pkg::item_t   s_item;
    tsd_pkg::item_t   held_item;
    logic             held_valid;
    logic             take;
    logic             is_last;
    logic             can_load;
    tsd_pkg::result_t dec_result;
    tsd_pkg::result_t out_result;

    // Clamp register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_temp_reg <= tsd_pkg::MAX_TEMP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_temp_reg <= cfg_data;
        end
    end

    // Unpack input payload
    assign s_item.data_byte   = s_axis_tdata[7:0];
    assign s_item.temp_adjust = s_axis_tdata[15:8];
    assign s_item.family_code = s_axis_tuser;

    // Held item advances when the result register can take a result
    assign take = held_valid && can_load;

    tsd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (s_item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    tsd_decode
    #(
        .SCRATCHPAD_LENGTH (SCRATCHPAD_LENGTH)
    )
    u_decode
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (held_item),
        .max_temp (max_temp_reg),
        .is_last  (is_last),
        .result   (dec_result)
    );

    tsd_out_stage u_out_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take && is_last),
        .load_result (dec_result),
        .can_load    (can_load),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (out_result)
    );

    // Pack result payload
    assign m_axis_tdata = {2'b00, out_result.temp_fraction, out_result.temp_integer};
    assign m_axis_tuser = out_result.status;

endmodule

[rtl/core/tsd_in_stage.sv]
// ----------------------------------------------------------------------------
// tsd_in_stage
// Input register: holds one accepted byte item until the decode logic
// takes it.
// ----------------------------------------------------------------------------
module tsd_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tsd_pkg::item_t in_item,
    input  logic           take,
    output logic           held_valid,
    output tsd_pkg::item_t held_item
);

    logic           valid_reg;
    logic           valid_next;
    tsd_pkg::item_t item_reg;

    // Free when empty or when the held item leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload load on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

[rtl/core/tsd_decode.sv]
// ----------------------------------------------------------------------------
// tsd_decode
// Running CRC, byte position and raw reading capture; on the last byte of
// a scratchpad forms the status and the adjusted, clamped temperature.
// ----------------------------------------------------------------------------
module tsd_decode
#(
    parameter int SCRATCHPAD_LENGTH = 9
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  tsd_pkg::item_t     item,
    input  logic [15:0]        max_temp,
    output logic               is_last,
    output tsd_pkg::result_t   result
);

    localparam int POS_W = $clog2(SCRATCHPAD_LENGTH);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(SCRATCHPAD_LENGTH - 1);

    logic [7:0]       crc_reg;
    logic [7:0]       crc_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       raw_low_reg;
    logic [7:0]       raw_high_reg;

    logic [7:0]         crc_upd;
    logic [15:0]        raw;
    logic [15:0]        base_temp;
    logic [15:0]        sum_temp;
    logic [13:0]        frac;
    logic               known_family;

    // CRC and position update
    assign crc_upd  = tsd_pkg::crc8_byte(crc_reg, item.data_byte);
    assign is_last  = (pos_reg == LAST_POS);
    assign crc_next = is_last ? 8'h00 : crc_upd;
    assign pos_next = is_last ? '0 : pos_reg + POS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= 8'h00;
            pos_reg      <= '0;
            raw_low_reg  <= 8'h00;
            raw_high_reg <= 8'h00;
        end
        else if (take)
        begin
            crc_reg <= crc_next;
            pos_reg <= pos_next;
            if (pos_reg == '0)
            begin
                raw_low_reg <= item.data_byte;
            end
            if (pos_reg == POS_W'(1))
            begin
                raw_high_reg <= item.data_byte;
            end
        end
    end

    // Temperature conversion
    assign raw          = {raw_high_reg, raw_low_reg};
    assign known_family = (item.family_code == tsd_pkg::FAMILY_A) ||
                          (item.family_code == tsd_pkg::FAMILY_B);

    always_comb
    begin
        if (known_family)
        begin
            // shift by 4, fill top nibble when bits 8..11 of the result set
            base_temp = {{4{|raw[15:12]}}, raw[15:4]};
            frac      = 14'(raw[3:0]) * 14'(tsd_pkg::FRAC_STEP);
        end
        else
        begin
            base_temp = tsd_pkg::DEFAULT_TEMP;
            frac      = 14'd0;
        end
    end

    assign sum_temp = base_temp + {{8{item.temp_adjust[7]}}, item.temp_adjust};

    // Status and clamp
    always_comb
    begin
        result = '0;
        priority if (item.family_code == tsd_pkg::FAMILY_EMPTY)
        begin
            result.status = tsd_pkg::STATUS_EMPTY;
        end
        else if (crc_upd != 8'h00)
        begin
            result.status = tsd_pkg::STATUS_CRC_ERR;
        end
        else
        begin
            result.status        = tsd_pkg::STATUS_OK;
            result.temp_fraction = frac;
            if ($signed(sum_temp) > $signed(max_temp))
            begin
                result.temp_integer = $signed(max_temp);
            end
            else
            begin
                result.temp_integer = $signed(sum_temp);
            end
        end
    end

endmodule

[rtl/core/tsd_out_stage.sv]
// ----------------------------------------------------------------------------
// tsd_out_stage
// Result register on the master side; holds a result while the receiver
// stalls.
// ----------------------------------------------------------------------------
module tsd_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  tsd_pkg::result_t load_result,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_ready,
    output tsd_pkg::result_t out_result
);

    logic             valid_reg;
    logic             valid_next;
    tsd_pkg::result_t result_reg;

    // Register is free when empty or being drained this cycle
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams thermometer scratchpads into the decoder core, byte by byte, and
// checks every decoded reading against a cycle-free model of the CRC check,
// sign fix, adjustment and clamp. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SCRATCH_LEN = 9;

    // DUT ports
    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data      = 16'h0000;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'h0000;  // [7:0] data_byte, [15:8] temp_adjust
    logic [7:0]  s_axis_tuser  = 8'h00;     // [7:0] family_code
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [31:0] m_axis_tdata;              // [15:0] temp_integer, [29:16] temp_fraction
    logic [1:0]  m_axis_tuser;              // [1:0] status

    // Model state of the decoder
    logic [7:0]         scratch_crc    = 8'h00;
    logic [3:0]         byte_index     = 4'd0;
    logic [7:0]         raw_lo         = 8'h00;
    logic [7:0]         raw_hi         = 8'h00;
    logic signed [15:0] max_temp_limit = tsd_pkg::MAX_TEMP_RESET;

    // Readings predicted but not yet seen on the output
    tsd_pkg::result_t pending_readings [$];

    // Idling control and run statistics
    bit sender_gaps = 1'b1;
    bit sink_stalls = 1'b1;
    int error_count = 0;
    int bytes_taken = 0;
    int pads_sent   = 0;
    int n_ok        = 0;
    int n_crc_err   = 0;
    int n_empty     = 0;
    int n_clamps    = 0;

    thermometer_scratchpad_decoder_core #(
        .SCRATCHPAD_LENGTH (SCRATCH_LEN)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Run limit
    initial
    begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Reflected CRC-8, one bit at a time, LSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        int         k;
        c = crc;
        for (k = 0; k < 8; k++)
        begin
            fb = c[0] ^ b[k];
            c  = {1'b0, c[7:1]} ^ (fb ? tsd_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // Advance the model by one accepted byte; queue a reading after the last one
    task automatic decode_scratchpad_byte(input tsd_pkg::item_t it);
        logic [15:0]      raw;
        logic [15:0]      deg;
        logic [13:0]      frac;
        logic [1:0]       st;
        tsd_pkg::result_t r;
        scratch_crc = crc8_step(scratch_crc, it.data_byte);
        if (byte_index == 4'd0)
        begin
            raw_lo = it.data_byte;
        end
        else if (byte_index == 4'd1)
        begin
            raw_hi = it.data_byte;
        end
        if (byte_index != 4'(SCRATCH_LEN - 1))
        begin
            byte_index = byte_index + 4'd1;
        end
        else
        begin
            deg  = 16'h0000;
            frac = 14'd0;
            if (it.family_code == tsd_pkg::FAMILY_EMPTY)
            begin
                st = tsd_pkg::STATUS_EMPTY;
            end
            else if (scratch_crc != 8'h00)
            begin
                st = tsd_pkg::STATUS_CRC_ERR;
            end
            else
            begin
                st  = tsd_pkg::STATUS_OK;
                raw = {raw_hi, raw_lo};
                if (it.family_code == tsd_pkg::FAMILY_A ||
                    it.family_code == tsd_pkg::FAMILY_B)
                begin
                    frac = 14'(raw[3:0]) * 14'(tsd_pkg::FRAC_STEP);
                    deg  = {4'h0, raw[15:4]};
                end
                else
                begin
                    deg = tsd_pkg::DEFAULT_TEMP;
                end
                // sign fix of the 12-bit reading
                if (deg[11:8] != 4'h0)
                begin
                    deg[15:12] = 4'hF;
                end
                deg = deg + {{8{it.temp_adjust[7]}}, it.temp_adjust};
                if ($signed(deg) > max_temp_limit)
                begin
                    deg = max_temp_limit;
                    n_clamps++;
                end
            end
            r.temp_integer  = deg;
            r.temp_fraction = frac;
            r.status        = st;
            pending_readings.push_back(r);
            scratch_crc = 8'h00;
            byte_index  = 4'd0;
        end
    endtask

    // Input monitor: feed every accepted byte to the model
    always @(posedge clk)
    begin
        tsd_pkg::item_t it;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            it.data_byte   = s_axis_tdata[7:0];
            it.temp_adjust = s_axis_tdata[15:8];
            it.family_code = s_axis_tuser;
            decode_scratchpad_byte(it);
            bytes_taken++;
        end
    end

    // Result checker: compare each transfer with the oldest predicted reading
    always @(posedge clk)
    begin
        tsd_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("unexpected result: temp_integer %0d, temp_fraction %0d, status %0d",
                       $signed(m_axis_tdata[15:0]), m_axis_tdata[29:16], m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (m_axis_tdata[15:0] !== want.temp_integer)
                begin
                    $error("temp_integer: expected %0d, got %0d",
                           want.temp_integer, $signed(m_axis_tdata[15:0]));
                    error_count++;
                end
                if (m_axis_tdata[29:16] !== want.temp_fraction)
                begin
                    $error("temp_fraction: expected %0d, got %0d",
                           want.temp_fraction, m_axis_tdata[29:16]);
                    error_count++;
                end
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    error_count++;
                end
                case (want.status)
                    tsd_pkg::STATUS_OK:      n_ok++;
                    tsd_pkg::STATUS_CRC_ERR: n_crc_err++;
                    default:                 n_empty++;
                endcase
            end
        end
    end

    // Sink back-pressure
    always @(negedge clk)
    begin
        m_axis_tready <= sink_stalls ? ($urandom_range(99) >= 30) : 1'b1;
    end

    // One byte transfer; leaves tvalid high at the falling edge after the handshake
    task automatic send_byte(input logic [7:0] data, input logic [7:0] family,
                             input logic [7:0] adjust);
        while (sender_gaps && $urandom_range(99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {adjust, data};
        s_axis_tuser  <= family;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Whole scratchpad around a raw reading; family and adjustment are noise
    // except on the last byte
    task automatic send_reading(input logic [15:0] raw, input logic [7:0] family,
                                input logic [7:0] adjust, input bit crc_good);
        logic [7:0] pad [SCRATCH_LEN];
        logic [7:0] crc;
        int         i;
        pad[0] = raw[7:0];
        pad[1] = raw[15:8];
        for (i = 2; i < SCRATCH_LEN - 1; i++)
        begin
            pad[i] = 8'($urandom);
        end
        crc = 8'h00;
        for (i = 0; i < SCRATCH_LEN - 1; i++)
        begin
            crc = crc8_step(crc, pad[i]);
        end
        pad[SCRATCH_LEN - 1] = crc_good ? crc : crc ^ 8'($urandom_range(255, 1));
        for (i = 0; i < SCRATCH_LEN; i++)
        begin
            if (i == SCRATCH_LEN - 1)
            begin
                send_byte(pad[i], family, adjust);
            end
            else
            begin
                send_byte(pad[i], 8'($urandom), 8'($urandom));
            end
        end
        pads_sent++;
    endtask

    // Drop tvalid, wait for all readings, then let the pipeline drain
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Clamp register write, only while idle
    task automatic set_max_temperature(input logic signed [15:0] limit);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        max_temp_limit = limit;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Both sensor families at the reset clamp, with both adjustment extremes
    task automatic test_reset_clamp();
        send_reading(16'h0191, tsd_pkg::FAMILY_B, 8'h00, 1'b1);
        send_reading(16'hFF5E, tsd_pkg::FAMILY_A, 8'h7F, 1'b1);
        send_reading(16'hFFFF, tsd_pkg::FAMILY_B, 8'h80, 1'b1);
    endtask

    // Unknown families report the fixed reading
    task automatic test_other_families();
        send_reading(16'($urandom), 8'h10, 8'h00, 1'b1);
        send_reading(16'($urandom), 8'hFF, 8'h80, 1'b1);
    endtask

    // Empty entry wins over a bad CRC; a bad CRC on a real sensor
    task automatic test_error_status();
        send_reading(16'($urandom), tsd_pkg::FAMILY_EMPTY, 8'($urandom), 1'b0);
        send_reading(16'($urandom), tsd_pkg::FAMILY_EMPTY, 8'($urandom), 1'b1);
        send_reading(16'h0191, tsd_pkg::FAMILY_B, 8'h05, 1'b0);
    endtask

    // Clamp at the lowest value and at a value inside the sensor range, then back to the highest
    task automatic test_clamp_extremes();
        wait_idle();
        set_max_temperature(16'sh8000);
        send_reading(16'h0000, tsd_pkg::FAMILY_B, 8'h00, 1'b1);
        wait_idle();
        set_max_temperature(16'sd20);
        send_reading(16'h0191, tsd_pkg::FAMILY_B, 8'h00, 1'b1);
        send_reading(16'h0140, tsd_pkg::FAMILY_A, 8'h80, 1'b1);
        wait_idle();
        set_max_temperature(16'sh7FFF);
    endtask

    // One phase of random scratchpads under a given clamp
    task automatic test_random_readings(input logic signed [15:0] limit, input int n_pads);
        logic [15:0] raw;
        logic [7:0]  family;
        int          pick;
        int          n;
        wait_idle();
        set_max_temperature(limit);
        for (n = 0; n < n_pads; n++)
        begin
            // mostly plausible readings, the rest any 16-bit word
            raw[7:0] = 8'($urandom);
            if ($urandom_range(99) < 70)
            begin
                raw[15:8] = $urandom_range(1) ? 8'($urandom_range(7))
                                              : 8'(8'hF8 + $urandom_range(7));
            end
            else
            begin
                raw[15:8] = 8'($urandom);
            end
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                family = tsd_pkg::FAMILY_B;
            end
            else if (pick < 65)
            begin
                family = tsd_pkg::FAMILY_A;
            end
            else if (pick < 72)
            begin
                family = tsd_pkg::FAMILY_EMPTY;
            end
            else
            begin
                family = 8'($urandom);
            end
            send_reading(raw, family, 8'($urandom), $urandom_range(99) < 80);
        end
    endtask

    // Test sequence
    initial
    begin
        int drain;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_clamp();
        test_other_families();
        test_error_status();
        test_clamp_extremes();

        test_random_readings(16'sh7FFF, 18);
        test_random_readings(16'sd25, 18);
        test_random_readings(16'sd0, 18);
        // long stretch with no idling on either side
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random_readings(16'sh8000, 18);
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        test_random_readings(16'($urandom), 18);
        test_random_readings(-16'sd40, 18);

        // drain, with a bound
        s_axis_tvalid <= 1'b0;
        drain = 0;
        while (pending_readings.size() != 0 && drain < 10000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (pending_readings.size() != 0)
        begin
            $error("%0d readings never arrived", pending_readings.size());
            error_count++;
        end

        $display("Decoded %0d scratchpads (%0d bytes): %0d ok, %0d CRC errors, %0d empty",
                 pads_sent, bytes_taken, n_ok, n_crc_err, n_empty);
        $display("Clamp limits from -32768 to 32767 applied, %0d readings clamped", n_clamps);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
